FILE: rtl/core/wheel_speed_meter_defines.svh
// Assertion macros for the wheel speed meter RTL.
`ifndef WHEEL_SPEED_METER_DEFINES_SVH
`define WHEEL_SPEED_METER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define WSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define WSM_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define WSM_ASSERT(lbl, prop, msg)
`define WSM_ASSERT_NR(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/wsm_pkg.sv
// Package: widths, register codes and shared types of the wheel speed meter.
`default_nettype none
package wsm_pkg;
    localparam int COUNT_BITS  = 16;
    localparam int TIME_BITS   = 32;
    localparam int NOW_W       = 32;
    localparam int MAG_W       = 8;
    localparam int CIRC_W      = 12;
    localparam int INTV_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SPEED_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGNETS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

    localparam logic [MAG_W-1:0]  MAGNETS_RST  = 8'd1;
    localparam logic [CIRC_W-1:0] CIRC_RST     = 12'd2100;
    localparam logic [INTV_W-1:0] INTERVAL_RST = 16'd1000;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 17'd99990;

    // count*circ, then *36 (six more bits)
    localparam int PROD_W = COUNT_BITS + CIRC_W;
    localparam int NUM_W  = PROD_W + 6;
    localparam int DEN_W  = MAG_W + TIME_BITS;
    // one extra quotient bit flags overflow past the speed range
    localparam int QUOT_W = SPEED_W + 1;
    localparam int DIV_W  = DEN_W + SPEED_W;
    localparam int REM_W  = (NUM_W > DIV_W) ? NUM_W : DIV_W;
    localparam int STEP_W = $clog2(QUOT_W);

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_sts;
endpackage
`default_nettype wire

FILE: rtl/core/wsm_div.sv
// Restoring divider: one compare-subtract per cycle, QUOT_W quotient bits.
`default_nettype none
module wsm_div
    import wsm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output t_div_sts              o_sts
);
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [REM_W-1:0]  r_dvs, n_dvs;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [REM_W:0]    diff;

    // divisor starts aligned to the top quotient bit
    assign diff = {1'b0, r_rem} - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(QUOT_W - 1);
            n_rem  = REM_W'(i_num);
            n_dvs  = REM_W'({i_den, {SPEED_W{1'b0}}});
            n_quot = '0;
        end else if (r_busy) begin
            if (!diff[REM_W]) begin
                n_rem = diff[REM_W-1:0];
            end
            n_quot = {r_quot[QUOT_W-2:0], ~diff[REM_W]};
            n_dvs  = r_dvs >> 1;
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_sts.done = r_done;
    assign o_sts.quot = r_quot;
endmodule
`default_nettype wire

FILE: rtl/core/wheel_speed_meter.sv
// Top level: pulse counting, interval check, speed sequencer and output register.
// Sequence: a poll that closes no interval is taken in S_IDLE alone; a closing poll passes S_MUL,
//   S_NUM, S_DIV (the divider) and S_OUT to the output register; a zero count or divisor skips S_DIV.
// Throughput: one poll per cycle while no interval closes; an update holds the input until S_OUT
//   hands its result to the output register, and S_OUT waits while the output stalls.
// Reset (sync, active low): state and output valid cleared; config to 1 magnet, 2100 mm, 1000 ms.
`default_nettype none
`include "wheel_speed_meter_defines.svh"
module wheel_speed_meter
    import wsm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // poll channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_switch_level,
    input  wire logic [NOW_W-1:0]      i_now_ms,
    // speed channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [SPEED_W-1:0]         o_speed_tenths_kmh,
    // config write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a poll
    localparam logic [2:0] S_MUL  = 3'd1;  // count*circ and magnets*elapsed
    localparam logic [2:0] S_NUM  = 3'd2;  // special cases or divider start
    localparam logic [2:0] S_DIV  = 3'd3;  // divider running
    localparam logic [2:0] S_OUT  = 3'd4;  // hand result to output register

    logic [2:0]            r_state, n_state;
    logic [MAG_W-1:0]      r_magnets;
    logic [CIRC_W-1:0]     r_circ;
    logic [INTV_W-1:0]     r_interval;
    logic                  r_prev, n_prev;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TIME_BITS-1:0]  r_last, n_last;
    logic [COUNT_BITS-1:0] r_snap, n_snap;
    logic [TIME_BITS-1:0]  r_elapsed, n_elapsed;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [DEN_W-1:0]      r_den, n_den;
    logic [SPEED_W-1:0]    r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    logic [SPEED_W-1:0]    r_speed, n_speed;

    logic                  in_beat;
    logic                  cfg_beat;
    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  elapsed;
    logic [COUNT_BITS-1:0] count_upd;
    logic [NUM_W-1:0]      num;
    logic                  div_start;
    logic [SPEED_W-1:0]    quot_sat;
    t_div_sts              div_sts;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_beat  = i_in_valid & o_in_ready;
    assign cfg_beat = i_cfg_valid & o_cfg_ready;

    assign now_t   = i_now_ms[TIME_BITS-1:0];
    assign elapsed = now_t - r_last;  // wraps at 2^TIME_BITS

    // rising edge counts, saturating at all ones
    assign count_upd = (i_switch_level && !r_prev && !(&r_count)) ?
                       r_count + 1'b1 : r_count;

    // *36 as *32 + *4
    assign num = (NUM_W'(r_prod) << 5) + (NUM_W'(r_prod) << 2);

    assign div_start = (r_state == S_NUM) && (r_prod != '0) && (r_den != '0);

    // top quotient bit means the quotient is past the 17-bit range
    assign quot_sat = (div_sts.quot[QUOT_W-1] || (div_sts.quot[SPEED_W-1:0] > SPEED_MAX)) ?
                      SPEED_MAX : div_sts.quot[SPEED_W-1:0];

    wsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (r_den),
        .o_sts   (div_sts)
    );

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_count     = r_count;
        n_last      = r_last;
        n_snap      = r_snap;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_den       = r_den;
        n_res       = r_res;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_speed     = r_speed;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_prev  = i_switch_level;
                    n_count = count_upd;
                    if (elapsed >= TIME_BITS'(r_interval)) begin
                        n_snap    = count_upd;
                        n_elapsed = elapsed;
                        n_count   = '0;
                        n_last    = now_t;
                        n_state   = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_snap) * PROD_W'(r_circ);
                n_den   = DEN_W'(r_magnets) * DEN_W'(r_elapsed);
                n_state = S_NUM;
            end
            S_NUM: begin
                // zero count or zero circumference gives 0; zero divisor saturates
                if (r_prod == '0) begin
                    n_res   = '0;
                    n_state = S_OUT;
                end else if (r_den == '0) begin
                    n_res   = SPEED_MAX;
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done) begin
                    n_res   = quot_sat;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_speed     = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= 1'b0;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_magnets   <= MAGNETS_RST;
            r_circ      <= CIRC_RST;
            r_interval  <= INTERVAL_RST;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (cfg_beat) begin
                unique case (i_cfg_index)
                    CFG_MAGNETS:  r_magnets  <= i_cfg_data[MAG_W-1:0];
                    CFG_CIRC:     r_circ     <= i_cfg_data[CIRC_W-1:0];
                    CFG_INTERVAL: r_interval <= i_cfg_data[INTV_W-1:0];
                    default: ;  // unmapped index, write dropped
                endcase
            end
        end
        r_snap    <= n_snap;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_den     <= n_den;
        r_res     <= n_res;
        r_speed   <= n_speed;
    end

    assign o_out_valid        = r_out_valid;
    assign o_speed_tenths_kmh = r_speed;

    `WSM_ASSERT(a_speed_range, o_out_valid |-> (o_speed_tenths_kmh <= SPEED_MAX), "speed range")
    `WSM_ASSERT(a_done_in_div, div_sts.done |-> (r_state == S_DIV), "divider done outside divide")
    `WSM_ASSERT_NR(a_reset_clean, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset left block busy")
endmodule
`default_nettype wire
